/* rtl/sorted_double_ended_buffer_macros.svh */
// Assertion macros for the sorted double-ended buffer.
// Used by files that carry concurrent checks; relies on clk and rst_n in scope.
`ifndef SORTED_DOUBLE_ENDED_BUFFER_MACROS_SVH
`define SORTED_DOUBLE_ENDED_BUFFER_MACROS_SVH
`ifndef SYNTHESIS
`define SDEB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SDEB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SDEB_ASSERT(lbl, prop, msg)
`define SDEB_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* rtl/sdeb_pkg.sv */
// Shared types and codes for the sorted double-ended buffer.
// No dependencies; imported by every module of the block.
package sdeb_pkg;

  localparam int KEY_W   = 32;
  localparam int COUNT_W = 8;

  localparam logic [1:0] REQ_INSERT   = 2'd0;
  localparam logic [1:0] REQ_TAKE_MIN = 2'd1;
  localparam logic [1:0] REQ_TAKE_MAX = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]              req_type;
    logic signed [KEY_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key_out;
    logic [1:0]              status;
    logic [COUNT_W-1:0]      count;
  } out_item_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT
  } cell_op_t;

  // Broadcast to every cell of a chain in the cycle an item is accepted.
  typedef struct packed {
    cell_op_t                op;
    logic signed [KEY_W-1:0] key;
  } cell_ctrl_t;

endpackage

/* rtl/sdeb_cell.sv */
// One cell of an ascending sorted chain: holds a single key.
// Depends on sdeb_pkg; instantiated in a row by sdeb_chain.
module sdeb_cell (
  input  logic                            clk,
  input  sdeb_pkg::cell_ctrl_t            ctrl,
  input  logic                            occ,
  input  logic                            tail,
  input  logic signed [sdeb_pkg::KEY_W-1:0] left_key,
  input  logic                            left_lt,
  input  logic signed [sdeb_pkg::KEY_W-1:0] right_key,
  output logic signed [sdeb_pkg::KEY_W-1:0] key_o,
  output logic                            lt_o
);
  import sdeb_pkg::*;

  logic signed [KEY_W-1:0] key_r;
  logic signed [KEY_W-1:0] key_nxt;

  // The new key belongs before this cell's key, so this key moves right.
  assign lt_o  = occ && (ctrl.key < key_r);
  assign key_o = key_r;

  always_comb begin
    key_nxt = key_r;
    unique case (ctrl.op)
      CELL_HOLD: key_nxt = key_r;
      CELL_INSERT: begin
        if (left_lt) begin
          key_nxt = left_key;
        end else if (lt_o || tail) begin
          key_nxt = ctrl.key;
        end
      end
      CELL_SHIFT: key_nxt = right_key;
      default: key_nxt = key_r;
    endcase
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule

/* rtl/sdeb_chain.sv */
// A row of sdeb_cell instances holding keys in ascending order from cell 0.
// Depends on sdeb_pkg and sdeb_cell.
module sdeb_chain #(
  parameter  int DEPTH = 128,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                              clk,
  input  sdeb_pkg::cell_ctrl_t              ctrl,
  input  logic [CNT_W-1:0]                  count,
  output logic signed [sdeb_pkg::KEY_W-1:0] head_key
);
  import sdeb_pkg::*;

  logic signed [KEY_W-1:0] key_w [DEPTH];
  logic                    lt_w  [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                    occ;
    logic                    tail;
    logic signed [KEY_W-1:0] left_key;
    logic                    left_lt;
    logic signed [KEY_W-1:0] right_key;

    assign occ  = CNT_W'(i) < count;
    assign tail = CNT_W'(i) == count;

    if (i == 0) begin : g_first
      assign left_key = '0;
      assign left_lt  = 1'b0;
    end else begin : g_inner_left
      assign left_key = key_w[i-1];
      assign left_lt  = lt_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_key = key_w[i];
    end else begin : g_inner_right
      assign right_key = key_w[i+1];
    end

    sdeb_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occ       (occ),
      .tail      (tail),
      .left_key  (left_key),
      .left_lt   (left_lt),
      .right_key (right_key),
      .key_o     (key_w[i]),
      .lt_o      (lt_w[i])
    );
  end

  assign head_key = key_w[0];

endmodule

/* rtl/sorted_double_ended_buffer.sv */
// Sorted double-ended buffer: bounded store of signed keys with insert,
// remove-smallest and remove-largest requests. Depends on sdeb_pkg, sdeb_chain.
//
// Use: an item on in_item (req_type, key) is taken at a rising edge with
// in_valid high and in_stall low. Every item gives one result on out_item
// (key_out, status, count), held with out_valid until out_stall is low.
// The result is registered at the acceptance edge.
// Throughput is one item per cycle while the receiver does not stall.
// The keys live in two rows of cells that all update in the same cycle: one
// row ascending and one holding inverted keys, so both the smallest and the
// largest key sit in cell 0 of a row. A removal shifts one row left and only
// shortens the other; an insert moves every larger key one cell right.
// An insert into a full store or a removal from an empty one leaves the
// keys untouched and reports the error in status.
// Reset empties the store and drops any waiting result; no clearing pass.
// While a result waits under out_stall, in_stall is raised and no item is
// taken; the waiting result stays unchanged.
module sorted_double_ended_buffer #(
  parameter int CAPACITY = 128
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sdeb_pkg::in_item_t  in_item,
  input  logic                in_valid,
  output logic                in_stall,
  output sdeb_pkg::out_item_t out_item,
  output logic                out_valid,
  input  logic                out_stall
);
  import sdeb_pkg::*;

  `include "sorted_double_ended_buffer_macros.svh"

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0]        count_r;
  logic [CNT_W-1:0]        count_nxt;
  logic                    out_valid_r;
  logic                    out_valid_nxt;
  out_item_t               out_item_r;
  out_item_t               out_item_nxt;
  logic                    in_fire;
  logic                    full;
  logic                    empty;
  cell_ctrl_t              asc_ctrl;
  cell_ctrl_t              desc_ctrl;
  logic signed [KEY_W-1:0] min_key;
  logic signed [KEY_W-1:0] inv_max_key;
  logic signed [KEY_W-1:0] max_key;

  assign in_stall = out_valid_r && out_stall;
  assign in_fire  = in_valid && !in_stall;
  assign full     = count_r == CNT_W'(CAPACITY);
  assign empty    = count_r == '0;
  assign max_key  = ~inv_max_key;

  always_comb begin
    asc_ctrl.op   = CELL_HOLD;
    asc_ctrl.key  = in_item.key;
    desc_ctrl.op  = CELL_HOLD;
    desc_ctrl.key = ~in_item.key;
    count_nxt     = count_r;
    out_item_nxt.key_out = '0;
    out_item_nxt.status  = ST_OK;
    if (in_fire) begin
      case (in_item.req_type)
        REQ_INSERT: begin
          if (full) begin
            out_item_nxt.status = ST_FULL;
          end else begin
            asc_ctrl.op  = CELL_INSERT;
            desc_ctrl.op = CELL_INSERT;
            count_nxt    = count_r + 1'b1;
          end
        end
        REQ_TAKE_MIN: begin
          if (empty) begin
            out_item_nxt.status = ST_EMPTY;
          end else begin
            // The inverted row loses its last cell simply by the count dropping.
            asc_ctrl.op          = CELL_SHIFT;
            out_item_nxt.key_out = min_key;
            count_nxt            = count_r - 1'b1;
          end
        end
        REQ_TAKE_MAX: begin
          if (empty) begin
            out_item_nxt.status = ST_EMPTY;
          end else begin
            desc_ctrl.op         = CELL_SHIFT;
            out_item_nxt.key_out = max_key;
            count_nxt            = count_r - 1'b1;
          end
        end
        default: ;
      endcase
    end
    out_item_nxt.count = COUNT_W'(count_nxt);
  end

  assign out_valid_nxt = in_fire || (out_valid_r && out_stall);

  sdeb_chain #(.DEPTH(CAPACITY)) u_asc_chain (
    .clk      (clk),
    .ctrl     (asc_ctrl),
    .count    (count_r),
    .head_key (min_key)
  );

  sdeb_chain #(.DEPTH(CAPACITY)) u_desc_chain (
    .clk      (clk),
    .ctrl     (desc_ctrl),
    .count    (count_r),
    .head_key (inv_max_key)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_item  = out_item_r;
  assign out_valid = out_valid_r;

  `SDEB_ASSERT(a_count_bound, count_r <= CNT_W'(CAPACITY), "count exceeds capacity")
  `SDEB_ASSERT(a_heads_ordered, (count_r != '0) |-> (min_key <= max_key), "smallest key above largest")
  `SDEB_ASSERT_NEXT(a_insert_grows, in_fire && in_item.req_type == REQ_INSERT && !full, count_r == $past(count_r) + 1'b1, "insert did not grow count")
  `SDEB_ASSERT(a_stall_only_when_held, in_stall |-> out_valid_r, "input stalled with no result held")

endmodule

/* test/tb_sorted_double_ended_buffer.sv */
// Self-checking testbench for sorted_double_ended_buffer.
// Needs sdeb_pkg and the block's RTL. A short table of requests is followed by
// random fill and drain runs, checked against table values or a sorted-queue predictor.
module tb_sorted_double_ended_buffer;
  timeunit 1ns;
  timeprecision 1ps;

  import sdeb_pkg::*;

  localparam int         CAPACITY    = 128;
  localparam int         N_RANDOM    = 420;
  localparam int         HOLD_CYCLES = 60;
  localparam int         CYCLE_LIMIT = 200000;
  localparam logic [1:0] REQ_UNUSED  = 2'd3;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  in_item_t  in_item   = '0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  out_item_t out_item;
  logic      out_valid;
  logic      out_stall = 1'b0;

  sorted_double_ended_buffer #(
    .CAPACITY(CAPACITY)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_item (out_item),
    .out_valid(out_valid),
    .out_stall(out_stall)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Keys the block should hold, smallest first, and results still to arrive.
  logic signed [KEY_W-1:0] held_keys[$];
  out_item_t               pending_results[$];

  int   mismatches   = 0;
  int   results_seen = 0;
  int   cycle_count  = 0;
  int   stall_left   = 0;
  logic calm         = 1'b0;
  logic hold_on      = 1'b0;

  typedef struct {
    in_item_t  stim;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  localparam int N_DIR = 21;
  dir_row_t dir_rows [N_DIR] = '{
    '{'{REQ_TAKE_MIN, 32'sd0},          1'b1, '{32'sd0, ST_EMPTY, 8'd0}},
    '{'{REQ_TAKE_MAX, 32'sh7fffffff},   1'b1, '{32'sd0, ST_EMPTY, 8'd0}},
    '{'{REQ_UNUSED, -32'sd1},           1'b1, '{32'sd0, ST_OK, 8'd0}},
    '{'{REQ_INSERT, 32'sh7fffffff},     1'b1, '{32'sd0, ST_OK, 8'd1}},
    '{'{REQ_INSERT, 32'sh80000000},     1'b1, '{32'sd0, ST_OK, 8'd2}},
    '{'{REQ_INSERT, 32'sd0},            1'b1, '{32'sd0, ST_OK, 8'd3}},
    '{'{REQ_INSERT, -32'sd1},           1'b1, '{32'sd0, ST_OK, 8'd4}},
    '{'{REQ_INSERT, 32'sd1},            1'b1, '{32'sd0, ST_OK, 8'd5}},
    '{'{REQ_INSERT, -32'sd1},           1'b1, '{32'sd0, ST_OK, 8'd6}},
    '{'{REQ_UNUSED, 32'sh12345678},     1'b1, '{32'sd0, ST_OK, 8'd6}},
    '{'{REQ_TAKE_MIN, 32'sd0},          1'b1, '{32'sh80000000, ST_OK, 8'd5}},
    '{'{REQ_TAKE_MAX, 32'sd0},          1'b1, '{32'sh7fffffff, ST_OK, 8'd4}},
    '{'{REQ_TAKE_MIN, 32'sh55555555},   1'b0, '0},
    '{'{REQ_TAKE_MAX, 32'shaaaaaaaa},   1'b0, '0},
    '{'{REQ_INSERT, 32'sh80000000},     1'b0, '0},
    '{'{REQ_INSERT, 32'sh7fffffff},     1'b0, '0},
    '{'{REQ_TAKE_MAX, 32'sd0},          1'b0, '0},
    '{'{REQ_TAKE_MIN, 32'sd0},          1'b0, '0},
    '{'{REQ_TAKE_MIN, 32'sd0},          1'b0, '0},
    '{'{REQ_TAKE_MAX, 32'sd0},          1'b0, '0},
    '{'{REQ_TAKE_MIN, 32'sd0},          1'b1, '{32'sd0, ST_EMPTY, 8'd0}}
  };

  // Applies one request to the predicted store and returns its result.
  function automatic out_item_t serve_request(input in_item_t req);
    out_item_t res;
    int        pos;
    res = '0;
    case (req.req_type)
      REQ_INSERT: begin
        if (held_keys.size() >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          pos = held_keys.size();
          while (pos > 0 && req.key < held_keys[pos-1]) pos--;
          held_keys.insert(pos, req.key);
        end
      end
      REQ_TAKE_MIN: begin
        if (held_keys.size() == 0) res.status = ST_EMPTY;
        else res.key_out = held_keys.pop_front();
      end
      REQ_TAKE_MAX: begin
        if (held_keys.size() == 0) res.status = ST_EMPTY;
        else res.key_out = held_keys.pop_back();
      end
      default: ;
    endcase
    res.count = COUNT_W'(held_keys.size());
    return res;
  endfunction

  // Offers one item, possibly after an idle burst, and records its result
  // once the block has taken it. Called at a rising edge.
  task automatic offer_item(input in_item_t it, input bit typed, input out_item_t want);
    out_item_t predicted;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_item  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = serve_request(it);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic note_mismatch(input string field, input logic signed [KEY_W-1:0] want,
                               input logic signed [KEY_W-1:0] got);
    $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    mismatches++;
  endtask

  initial begin
    in_item_t it;
    int       random_items;
    int       roll;
    int       near;
    bit       fill_mode;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIR; i++)
      offer_item(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);

    // Runs of mostly inserts up to the full store and a little beyond, then
    // runs of mostly removals down to empty and a little beyond.
    random_items = 0;
    fill_mode    = 1'b1;
    while (random_items < N_RANDOM) begin
      calm <= (random_items >= 200 && random_items < 240) || random_items >= N_RANDOM - 60;
      if (fill_mode && held_keys.size() == CAPACITY && $urandom_range(0, 3) == 0)
        fill_mode = 1'b0;
      else if (!fill_mode && held_keys.size() == 0 && $urandom_range(0, 3) == 0)
        fill_mode = 1'b1;
      roll = $urandom_range(0, 99);
      if (roll < 3) it.req_type = REQ_UNUSED;
      else if (fill_mode ? roll < 85 : roll < 18) it.req_type = REQ_INSERT;
      else if ($urandom_range(0, 1) == 1) it.req_type = REQ_TAKE_MIN;
      else it.req_type = REQ_TAKE_MAX;
      case ($urandom_range(0, 9))
        0: it.key = 32'sh80000000;
        1: it.key = 32'sh7fffffff;
        2, 3, 4: begin
          near   = $urandom_range(0, 15);
          it.key = near - 8;
        end
        default: it.key = $urandom;
      endcase
      offer_item(it, 1'b0, '0);
      if (it.req_type != REQ_UNUSED) random_items++;
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing outstanding, expected none, got %0d/%0d/%0d",
                 $time, out_item.key_out, out_item.status, out_item.count);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_item.key_out !== want.key_out)
          note_mismatch("key_out", want.key_out, out_item.key_out);
        if (out_item.status !== want.status)
          note_mismatch("status", KEY_W'(want.status), KEY_W'(out_item.status));
        if (out_item.count !== want.count)
          note_mismatch("count", KEY_W'(want.count), KEY_W'(out_item.count));
      end
    end
  end

  // Receiver stalls in random bursts, except in calm stretches or during the
  // long hold, which is timed by the process below.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (hold_on) begin
      out_stall <= 1'b1;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 9);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // One long hold while the sender keeps offering, so that the input stalls.
  initial begin
    while (results_seen < 150) @(posedge clk);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

endmodule
